// ----- hw/rtl/imhtq_pkg.sv -----
`default_nettype none
package imhtq_pkg;

  localparam int unsigned KeyW   = 10;
  localparam int unsigned SecW   = 32;
  localparam int unsigned SlotW  = 7;
  localparam int unsigned MapMax = 1024;

  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActCancel = 2'd1;
  localparam logic [1:0] ActChange = 2'd2;
  localparam logic [1:0] ActCheck  = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StPresent = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StAbsent  = 2'd3;

  localparam logic [SlotW-1:0] SlotAbsent = 7'd127;
  localparam logic [9:0]       MsPerSec   = 10'd1000;
  localparam logic [41:0]      DelayMax   = 42'd2147483647;
  localparam logic [31:0]      DelayEmpty = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [SecW-1:0] expiry;
  } entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/indexed_min_heap_timer_queue.sv -----
`default_nettype none
// Channel  Dir  Handshake                 Word
// s_axis   in   s_axis_tvalid/tready      tdata[79:0]: action, timer_key, expiry_second,
//                                         current_second, zero fill
// m_axis   out  m_axis_tvalid/tready      tdata[47:0]: status, expired_key, next_delay_ms;
//                                         tuser: expired_valid; tlast: last
// One word at a time. Add, cancel and change walk the heap level by level, and each
// level is read through the single read port of the heap memory.
// A check pops one timer per pass, each pass a sift down plus a root read.
// After reset the key map is cleared, one entry per cycle (KEY_COUNT entries, at most
// 1024), while s_axis_tready stays low. A stalled output holds the sequencer.
module indexed_min_heap_timer_queue #(
  parameter int unsigned HEAP_CAPACITY = 64,
  parameter int unsigned KEY_COUNT     = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action[1:0], timer_key[11:2], expiry_second[43:12], current_second[75:44], zero
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], expired_key[11:2], next_delay_ms[43:12], zero
  output logic [47:0]      m_axis_tdata,
  // expired_valid[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int unsigned IW   = $clog2(HEAP_CAPACITY);
  localparam int unsigned CW   = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned MapD = (KEY_COUNT < imhtq_pkg::MapMax) ? KEY_COUNT
                                                                  : imhtq_pkg::MapMax;
  localparam int unsigned MIW  = $clog2(MapD);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_UPC   = 4'd5;
  localparam logic [3:0] S_DN    = 4'd6;
  localparam logic [3:0] S_DNL   = 4'd7;
  localparam logic [3:0] S_DNR   = 4'd8;
  localparam logic [3:0] S_DNC   = 4'd9;
  localparam logic [3:0] S_PLACE = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_DSUB  = 4'd12;
  localparam logic [3:0] S_DMUL  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;
  localparam logic [3:0] S_POP   = 4'd15;

  imhtq_pkg::entry_t heap_mem [HEAP_CAPACITY];
  logic [imhtq_pkg::SlotW-1:0] map_mem [MapD];

  logic [3:0] state_q, state_d;
  logic [MIW-1:0] clr_q, clr_d;
  logic [1:0] act_q, act_d;
  logic [imhtq_pkg::KeyW-1:0] key_q, key_d;
  logic [31:0] exp_q, exp_d, now_q, now_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] pos_q, pos_d, bidx_q, bidx_d;
  imhtq_pkg::entry_t cur_q, cur_d, best_q, best_d;
  logic blt_q, blt_d;
  logic [1:0] stat_q, stat_d;
  logic popped_q, popped_d, pc_q, pc_d, emp_q, emp_d, due_q, due_d;
  logic [imhtq_pkg::KeyW-1:0] popkey_q, popkey_d, rkey_q, rkey_d;
  logic [31:0] diff_q, diff_d, dly_q, dly_d;

  logic mv_q, mv_d, ml_q, ml_d, mu_q, mu_d;
  logic [47:0] md_q, md_d;

  logic h_we;
  logic [IW-1:0] h_waddr, h_raddr;
  imhtq_pkg::entry_t h_wdata, hq;
  logic m_we;
  logic [MIW-1:0] m_waddr, m_raddr;
  logic [imhtq_pkg::SlotW-1:0] m_wdata, mq;

  logic in_map, present;
  logic [IW:0] lidx;
  logic [41:0] prod;
  logic [31:0] cmp_exp;

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      heap_mem[h_waddr] <= h_wdata;
    end
    hq <= heap_mem[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      map_mem[m_waddr] <= m_wdata;
    end
    mq <= map_mem[m_raddr];
  end

  assign in_map  = 32'(key_q) < KEY_COUNT;
  assign present = in_map && (mq != imhtq_pkg::SlotAbsent);
  assign lidx    = {pos_q, 1'b1};
  assign prod    = diff_q * imhtq_pkg::MsPerSec;
  assign cmp_exp = blt_q ? best_q.expiry : cur_q.expiry;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = mu_q;
  assign m_axis_tlast  = ml_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    act_d    = act_q;
    key_d    = key_q;
    exp_d    = exp_q;
    now_d    = now_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    bidx_d   = bidx_q;
    cur_d    = cur_q;
    best_d   = best_q;
    blt_d    = blt_q;
    stat_d   = stat_q;
    popped_d = popped_q;
    pc_d     = pc_q;
    emp_d    = emp_q;
    due_d    = due_q;
    popkey_d = popkey_q;
    rkey_d   = rkey_q;
    diff_d   = diff_q;
    dly_d    = dly_q;
    mv_d     = mv_q && !m_axis_tready;
    ml_d     = ml_q;
    mu_d     = mu_q;
    md_d     = md_q;
    h_we     = 1'b0;
    h_waddr  = pos_q;
    h_wdata  = cur_q;
    h_raddr  = '0;
    m_we     = 1'b0;
    m_waddr  = cur_q.key[MIW-1:0];
    m_wdata  = 7'(pos_q);
    m_raddr  = s_axis_tdata[2 +: MIW];

    unique case (state_q)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = imhtq_pkg::SlotAbsent;
        clr_d   = clr_q + 1'b1;
        if (clr_q == MIW'(MapD - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d    = s_axis_tdata[1:0];
          key_d    = s_axis_tdata[11:2];
          exp_d    = s_axis_tdata[43:12];
          now_d    = s_axis_tdata[75:44];
          stat_d   = imhtq_pkg::StOk;
          popped_d = 1'b0;
          state_d  = (s_axis_tdata[1:0] == imhtq_pkg::ActCheck) ? S_FIN : S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_FIN;
        cur_d   = '{key: key_q, expiry: exp_q};
        if (act_q == imhtq_pkg::ActAdd) begin
          if (!in_map) begin
            stat_d = imhtq_pkg::StAbsent;
          end else if (present) begin
            stat_d = imhtq_pkg::StPresent;
          end else if (cnt_q == CW'(HEAP_CAPACITY)) begin
            stat_d = imhtq_pkg::StFull;
          end else begin
            pos_d   = IW'(cnt_q);
            cnt_d   = cnt_q + 1'b1;
            state_d = S_UP;
          end
        end else if (!present) begin
          stat_d = imhtq_pkg::StAbsent;
        end else if (act_q == imhtq_pkg::ActChange) begin
          pos_d   = IW'(mq);
          state_d = S_UP;
        end else begin
          m_we    = 1'b1;
          m_waddr = key_q[MIW-1:0];
          m_wdata = imhtq_pkg::SlotAbsent;
          cnt_d   = cnt_q - 1'b1;
          pos_d   = IW'(mq);
          h_raddr = IW'(cnt_q - 1'b1);
          if (7'(mq) < 7'(cnt_q - 1'b1)) begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cur_d   = hq;
        state_d = S_UP;
      end
      S_UP: begin
        h_raddr = IW'((pos_q - 1'b1) >> 1);
        state_d = (pos_q == '0) ? S_DN : S_UPC;
      end
      S_UPC: begin
        if (cur_q.expiry < hq.expiry) begin
          h_we    = 1'b1;
          h_wdata = hq;
          m_we    = 1'b1;
          m_waddr = hq.key[MIW-1:0];
          pos_d   = IW'((pos_q - 1'b1) >> 1);
          state_d = S_UP;
        end else begin
          state_d = S_DN;
        end
      end
      S_DN: begin
        h_raddr = IW'(lidx);
        state_d = (8'(lidx) < 8'(cnt_q)) ? S_DNL : S_PLACE;
      end
      S_DNL: begin
        best_d  = hq;
        bidx_d  = IW'(lidx);
        blt_d   = hq.expiry < cur_q.expiry;
        h_raddr = IW'(lidx + 1'b1);
        state_d = (8'(lidx) + 8'd1 < 8'(cnt_q)) ? S_DNR : S_DNC;
      end
      S_DNR: begin
        if (hq.expiry < cmp_exp) begin
          best_d = hq;
          bidx_d = IW'(lidx + 1'b1);
          blt_d  = 1'b1;
        end
        state_d = S_DNC;
      end
      S_DNC: begin
        if (blt_q) begin
          h_we    = 1'b1;
          h_wdata = best_q;
          m_we    = 1'b1;
          m_waddr = best_q.key[MIW-1:0];
          pos_d   = bidx_q;
          state_d = S_DN;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        h_we    = 1'b1;
        m_we    = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        h_raddr = '0;
        state_d = S_DSUB;
      end
      S_DSUB: begin
        emp_d   = (cnt_q == '0);
        due_d   = hq.expiry <= now_q;
        diff_d  = hq.expiry - now_q;
        rkey_d  = hq.key;
        pc_d    = (cnt_q != '0) && (hq.expiry <= now_q);
        state_d = S_DMUL;
        if (act_q == imhtq_pkg::ActCheck && !popped_q && (cnt_q != '0)
            && (hq.expiry <= now_q)) begin
          state_d = S_POP;
        end
      end
      S_DMUL: begin
        if (emp_q) begin
          dly_d = imhtq_pkg::DelayEmpty;
        end else if (due_q) begin
          dly_d = '0;
        end else if (prod > imhtq_pkg::DelayMax) begin
          dly_d = imhtq_pkg::DelayMax[31:0];
        end else begin
          dly_d = prod[31:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          mu_d = popped_q;
          ml_d = (act_q != imhtq_pkg::ActCheck) || !pc_q;
          md_d = {4'd0, dly_q, (popped_q ? popkey_q : 10'd0), stat_q};
          state_d = (act_q == imhtq_pkg::ActCheck && pc_q) ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        m_we     = 1'b1;
        m_waddr  = rkey_q[MIW-1:0];
        m_wdata  = imhtq_pkg::SlotAbsent;
        popkey_d = rkey_q;
        popped_d = 1'b1;
        cnt_d    = cnt_q - 1'b1;
        h_raddr  = IW'(cnt_q - 1'b1);
        pos_d    = '0;
        state_d  = (cnt_q > CW'(1)) ? S_LOAD : S_FIN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      cnt_q    <= '0;
      popped_q <= 1'b0;
      mv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      popped_q <= popped_d;
      mv_q     <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    exp_q    <= exp_d;
    now_q    <= now_d;
    pos_q    <= pos_d;
    bidx_q   <= bidx_d;
    cur_q    <= cur_d;
    best_q   <= best_d;
    blt_q    <= blt_d;
    stat_q   <= stat_d;
    pc_q     <= pc_d;
    emp_q    <= emp_d;
    due_q    <= due_d;
    popkey_q <= popkey_d;
    rkey_q   <= rkey_d;
    diff_q   <= diff_d;
    dly_q    <= dly_d;
    ml_q     <= ml_d;
    mu_q     <= mu_d;
    md_q     <= md_d;
  end

endmodule
`default_nettype wire
